// ----- hdl/cais_pkg.sv -----
// Shared types, constants and character helpers for the include and flag scanner.
package cais_pkg;

  // Section size limit; bytes at positions from this value on are dropped
  localparam int unsigned MAX_SECTION_BYTES = 65536;
  localparam int unsigned COUNT_W = $clog2(MAX_SECTION_BYTES + 1);

  // Lookahead depth used for decisions, plus one byte of slack for streaming
  localparam int unsigned LOOK_DEPTH = 8;
  localparam int unsigned WIN_DEPTH  = LOOK_DEPTH + 1;
  localparam int unsigned WIN_IDX_W  = $clog2(WIN_DEPTH);
  localparam int unsigned FILL_W     = $clog2(WIN_DEPTH + 1);

  // Pattern lengths
  localparam int unsigned INC_LEN  = 8;
  localparam int unsigned FLAG_LEN = 5;

  typedef logic [7:0]  byte_t;
  typedef logic [1:0]  kind_t;
  typedef logic [6:0]  flag_num_t;
  typedef logic [15:0] offset_t;

  // Record kinds
  localparam kind_t KIND_INCLUDE = 2'd0;
  localparam kind_t KIND_FLAG    = 2'd1;
  localparam kind_t KIND_END     = 2'd2;

  // Character codes
  localparam byte_t CH_HASH  = 8'h23;
  localparam byte_t CH_UNDER = 8'h5F;
  localparam byte_t CH_F     = 8'h46;
  localparam byte_t CH_SLASH = 8'h2F;
  localparam byte_t CH_STAR  = 8'h2A;
  localparam byte_t CH_QUOTE = 8'h22;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_ZERO  = 8'h30;
  localparam byte_t CH_NINE  = 8'h39;

  // One result record
  typedef struct packed {
    kind_t     kind;
    flag_num_t num;
    offset_t   off;
    offset_t   len;
    logic      end_mark;
  } record_t;

  // Characters of "#include"
  function automatic byte_t inc_char(input logic [2:0] idx);
    byte_t c;
    case (idx)
      3'd0: c = CH_HASH;
      3'd1: c = 8'h69;
      3'd2: c = 8'h6E;
      3'd3: c = 8'h63;
      3'd4: c = 8'h6C;
      3'd5: c = 8'h75;
      3'd6: c = 8'h64;
      3'd7: c = 8'h65;
      default: c = CH_HASH;
    endcase
    return c;
  endfunction

  function automatic logic is_eol(input byte_t c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_space(input byte_t c);
    return (c == CH_SPACE) || (c == CH_TAB) || is_eol(c);
  endfunction

  function automatic logic is_digit(input byte_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// ----- hdl/cais_in_if.sv -----
// Input byte channel: one section byte and its final mark per request.
interface cais_in_if;
  import cais_pkg::*;

  logic  valid;
  logic  ready;
  byte_t text_byte;
  logic  final_byte;

  modport source (output valid, text_byte, final_byte, input ready);
  modport sink   (input valid, text_byte, final_byte, output ready);
endinterface

// ----- hdl/cais_out_if.sv -----
// Output record channel: one include, flag or end-of-section record per request.
interface cais_out_if;
  import cais_pkg::*;

  logic      valid;
  logic      ready;
  kind_t     record_kind;
  flag_num_t flag_number;
  offset_t   name_offset;
  offset_t   name_length;
  logic      end_mark;

  modport source (output valid, record_kind, flag_number, name_offset, name_length, end_mark,
                  input ready);
  modport sink   (input valid, record_kind, flag_number, name_offset, name_length, end_mark,
                  output ready);
endinterface

// ----- hdl/comment_aware_include_flag_scanner_top.sv -----
// Comment-aware scanner for #include names and _Fdd_ flags in one code section.
//
//   channel     | dir | payload                                          | request when
//   ------------+-----+--------------------------------------------------+------------------
//   text_in     | in  | text_byte, final_byte                            | valid && ready
//   record_out  | out | record_kind, flag_number, name_offset,           | valid && ready
//               |     | name_length, end_mark                            |
//
// Sustained rate is one byte per cycle while the output takes records: the scan unit
// advances the front of a nine-byte window by one position each cycle (or skips five or
// eight bytes on a match). A record is loaded into the output register by the step that
// handles the byte completing it, once the output slot is free. After the final byte,
// input is held off while the window drains, while an include line or flag name that is
// still open is flushed, and while the end record is loaded.
// A stalled output blocks only a step that makes a record; input is still taken
// until the window holds nine bytes. Reset (rst, synchronous) empties the window.
module comment_aware_include_flag_scanner_top (
  input  logic      clk,
  input  logic      rst,
  cais_in_if.sink   text_in,
  cais_out_if.source record_out
);
  import cais_pkg::*;

  // Scan modes
  localparam logic [1:0] MODE_NORMAL  = 2'd0;
  localparam logic [1:0] MODE_INCLUDE = 2'd1;
  localparam logic [1:0] MODE_FLAG    = 2'd2;

  localparam int unsigned POP_W = $clog2(INC_LEN + 1);

  // Window and scan state
  byte_t              win [WIN_DEPTH];
  logic [FILL_W-1:0]  fill;
  logic [1:0]         mode;
  logic               line_c;
  logic               block_c;
  logic               fq_seen;
  logic               lq_seen;
  offset_t            fq_off;
  offset_t            lq_off;
  flag_num_t          flag_num;
  offset_t            name_start;
  offset_t            head_pos;
  logic               fin;
  logic [COUNT_W-1:0] in_count;
  logic               out_valid;
  record_t            out_rec;

  // Next values
  byte_t              win_next [WIN_DEPTH];
  logic [FILL_W-1:0]  fill_next;
  logic [FILL_W-1:0]  fill_pop;
  logic [1:0]         mode_next;
  logic               line_next;
  logic               block_next;
  logic               fq_seen_next;
  logic               lq_seen_next;
  offset_t            fq_off_next;
  offset_t            lq_off_next;
  flag_num_t          flag_num_next;
  offset_t            name_start_next;

  // Scan step signals
  byte_t              b [LOOK_DEPTH];
  logic               lc;
  logic               bc;
  logic               inc_hit;
  logic               flag_hit;
  flag_num_t          flag_val;
  logic [POP_W-1:0]   pop;
  logic [POP_W-1:0]   pop_eff;
  logic               active;
  logic               emit;
  logic               tail_end;
  logic               go;
  logic               slot_free;
  record_t            rec_next;
  logic               in_fire;
  logic               append;
  logic [4:0]         src;

  // Front bytes, zero past the fill level
  always_comb begin
    for (int i = 0; i < LOOK_DEPTH; i++) begin
      b[i] = (FILL_W'(i) < fill) ? win[i] : '0;
    end
  end

  // Pattern matches at the front
  always_comb begin
    inc_hit = 1'b1;
    for (int i = 0; i < INC_LEN; i++) begin
      if (b[i] != inc_char(3'(i))) inc_hit = 1'b0;
    end
    flag_hit = (b[0] == CH_UNDER) && (b[1] == CH_F) && (b[4] == CH_UNDER) &&
               is_digit(b[2]) && is_digit(b[3]);
    flag_val = 7'({3'b0, b[2][3:0]}) * 7'd10 + 7'({3'b0, b[3][3:0]});
  end

  // One scan step
  always_comb begin
    pop             = '0;
    active          = 1'b0;
    emit            = 1'b0;
    tail_end        = 1'b0;
    rec_next        = '0;
    mode_next       = mode;
    lc              = line_c;
    bc              = block_c;
    fq_seen_next    = fq_seen;
    lq_seen_next    = lq_seen;
    fq_off_next     = fq_off;
    lq_off_next     = lq_off;
    flag_num_next   = flag_num;
    name_start_next = name_start;

    if (fill != '0) begin
      case (mode)
        MODE_INCLUDE: begin
          // rest of an include line: collect quote positions up to end of line
          active = 1'b1;
          pop    = POP_W'(1);
          if (b[0] == CH_QUOTE) begin
            if (!fq_seen) begin
              fq_seen_next = 1'b1;
              fq_off_next  = head_pos;
            end else begin
              lq_seen_next = 1'b1;
              lq_off_next  = head_pos;
            end
          end else if (is_eol(b[0])) begin
            mode_next = MODE_NORMAL;
            if (fq_seen && lq_seen) begin
              emit          = 1'b1;
              rec_next.kind = KIND_INCLUDE;
              rec_next.off  = fq_off + 16'd1;
              rec_next.len  = lq_off - fq_off - 16'd1;
            end
          end
        end
        MODE_FLAG: begin
          // flag name runs up to whitespace
          active = 1'b1;
          pop    = POP_W'(1);
          if (is_space(b[0])) begin
            mode_next     = MODE_NORMAL;
            emit          = 1'b1;
            rec_next.kind = KIND_FLAG;
            rec_next.num  = flag_num;
            rec_next.off  = name_start;
            rec_next.len  = head_pos - name_start;
          end
        end
        default: begin
          mode_next = MODE_NORMAL;
          if ((fill >= FILL_W'(LOOK_DEPTH)) || fin) begin
            active = 1'b1;
            // comment openers
            if ((fill >= FILL_W'(2)) && !lc && !bc) begin
              if ((b[0] == CH_SLASH) && (b[1] == CH_SLASH)) lc = 1'b1;
              else if ((b[0] == CH_SLASH) && (b[1] == CH_STAR)) bc = 1'b1;
            end
            // comment closers; slash-star-slash closes on its star
            if (lc && is_eol(b[0])) begin
              lc = 1'b0;
            end else if (bc && (fill >= FILL_W'(2)) && (b[0] == CH_STAR) &&
                         (b[1] == CH_SLASH)) begin
              bc = 1'b0;
            end
            // matches outside comments
            if (!lc && !bc && (fill >= FILL_W'(INC_LEN)) && inc_hit) begin
              pop          = POP_W'(INC_LEN);
              mode_next    = MODE_INCLUDE;
              fq_seen_next = 1'b0;
              lq_seen_next = 1'b0;
              fq_off_next  = '0;
              lq_off_next  = '0;
            end else if (!lc && !bc && (fill >= FILL_W'(FLAG_LEN)) && flag_hit) begin
              pop             = POP_W'(FLAG_LEN);
              mode_next       = MODE_FLAG;
              flag_num_next   = flag_val;
              name_start_next = head_pos + 16'(FLAG_LEN);
            end else begin
              pop = POP_W'(1);
            end
          end
        end
      endcase
    end else if (fin) begin
      // window empty after the final byte: flush pending record, then end record
      active = 1'b1;
      case (mode)
        MODE_INCLUDE: begin
          mode_next = MODE_NORMAL;
          if (fq_seen && lq_seen) begin
            emit          = 1'b1;
            rec_next.kind = KIND_INCLUDE;
            rec_next.off  = fq_off + 16'd1;
            rec_next.len  = lq_off - fq_off - 16'd1;
          end
        end
        MODE_FLAG: begin
          mode_next     = MODE_NORMAL;
          emit          = 1'b1;
          rec_next.kind = KIND_FLAG;
          rec_next.num  = flag_num;
          rec_next.off  = name_start;
          rec_next.len  = head_pos - name_start;
        end
        default: begin
          emit              = 1'b1;
          tail_end          = 1'b1;
          rec_next.kind     = KIND_END;
          rec_next.end_mark = 1'b1;
        end
      endcase
    end
    line_next  = lc;
    block_next = bc;
  end

  // Handshakes
  assign slot_free     = !out_valid || record_out.ready;
  assign go            = active && (!emit || slot_free);
  assign text_in.ready = !fin && (fill < FILL_W'(WIN_DEPTH));
  assign in_fire       = text_in.valid && text_in.ready;
  assign append        = in_fire && (in_count < COUNT_W'(MAX_SECTION_BYTES));
  assign pop_eff       = go ? pop : '0;
  assign fill_pop      = fill - FILL_W'(pop_eff);
  assign fill_next     = fill_pop + FILL_W'(append);

  // Window shift by the step's pop count, then append at the new fill level
  always_comb begin
    src = '0;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      src = 5'(i) + 5'(pop_eff);
      win_next[i] = (src < 5'(WIN_DEPTH)) ? win[src[WIN_IDX_W-1:0]] : '0;
    end
    if (append) win_next[fill_pop[WIN_IDX_W-1:0]] = text_in.text_byte;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      mode      <= MODE_NORMAL;
      line_c    <= 1'b0;
      block_c   <= 1'b0;
      fq_seen   <= 1'b0;
      lq_seen   <= 1'b0;
      head_pos  <= '0;
      fin       <= 1'b0;
      in_count  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (go && emit) out_valid <= 1'b1;
      else if (record_out.ready) out_valid <= 1'b0;

      if (go && tail_end) begin
        // section done: back to reset state for the next one
        fill     <= '0;
        mode     <= MODE_NORMAL;
        line_c   <= 1'b0;
        block_c  <= 1'b0;
        fq_seen  <= 1'b0;
        lq_seen  <= 1'b0;
        head_pos <= '0;
        fin      <= 1'b0;
        in_count <= '0;
      end else begin
        fill     <= fill_next;
        head_pos <= head_pos + 16'(pop_eff);
        in_count <= in_count + COUNT_W'(append);
        fin      <= fin || (in_fire && text_in.final_byte);
        if (go) begin
          mode    <= mode_next;
          line_c  <= line_next;
          block_c <= block_next;
          fq_seen <= fq_seen_next;
          lq_seen <= lq_seen_next;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    win <= win_next;
    if (go) begin
      fq_off     <= fq_off_next;
      lq_off     <= lq_off_next;
      flag_num   <= flag_num_next;
      name_start <= name_start_next;
    end
    if (go && emit) out_rec <= rec_next;
  end

  // Output channel
  assign record_out.valid       = out_valid;
  assign record_out.record_kind = out_rec.kind;
  assign record_out.flag_number = out_rec.num;
  assign record_out.name_offset = out_rec.off;
  assign record_out.name_length = out_rec.len;
  assign record_out.end_mark    = out_rec.end_mark;

`ifndef SYNTHESIS
  a_comment_excl: assert property (@(posedge clk) disable iff (rst)
    !(line_c && block_c))
    else $error("line and block comment state both set");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(WIN_DEPTH))
    else $error("window fill beyond capacity");

  a_flag_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_rec.kind == KIND_FLAG)) |-> (out_rec.num <= 7'd99))
    else $error("flag number out of range");

  a_end_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_rec.end_mark == (out_rec.kind == KIND_END)))
    else $error("end mark does not match record kind");
`endif

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the comment-aware include and flag scanner.
module tb_top;
  import cais_pkg::*;

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_INCLUDE_LINE,
    MODE_FLAG_NAME
  } scan_mode_t;

  localparam logic [63:0] INCLUDE_WORD = "#include";
  localparam int          MAX_PER_BYTE = 3;
  localparam record_t     END_REC      = '{KIND_END, 7'd0, 16'd0, 16'd0, 1'b1};

  logic clk;
  logic rst;

  cais_in_if  text_in ();
  cais_out_if record_out ();

  comment_aware_include_flag_scanner_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_in),
    .record_out (record_out)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  int in_idle_pct  = 19;
  int out_idle_pct = 57;
  int error_count  = 0;
  int bytes_in     = 0;
  int sections_in  = 0;
  int records_out  = 0;
  bit typed_section = 1'b0;

  record_t expected_records[$];
  byte_t   section_q[$];

  // Directed table: section text, number of typed records (-1: use scan model)
  string   dir_text[$];
  int      dir_count[$];
  record_t dir_records[$];

  // ---------------------------------------------------------------------------
  // Scan model state
  byte_t      look_q[$];
  int         sec_count    = 0;
  bit         in_line_cmt  = 1'b0;
  bit         in_block_cmt = 1'b0;
  scan_mode_t mode         = MODE_TEXT;
  bit         quote1_seen  = 1'b0;
  bit         quote2_seen  = 1'b0;
  int         quote1_pos   = 0;
  int         quote2_pos   = 0;
  int         flag_val     = 0;
  int         flag_name_pos = 0;
  record_t    step_records[$];

  function automatic record_t make_record(kind_t kind, int num, int off, int len, bit endm);
    record_t r;
    r.kind     = kind;
    r.num      = num[6:0];
    r.off      = off[15:0];
    r.len      = len[15:0];
    r.end_mark = endm;
    return r;
  endfunction

  function automatic byte_t look(int i);
    return (i < look_q.size()) ? look_q[i] : 8'h00;
  endfunction

  function automatic void drop(int k);
    if (k >= look_q.size()) look_q.delete();
    else repeat (k) void'(look_q.pop_front());
  endfunction

  function automatic bit line_end(byte_t c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic bit name_stop(byte_t c);
    return (c == CH_SPACE) || (c == CH_TAB) || line_end(c);
  endfunction

  function automatic bit digit(byte_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // At most three records per byte; anything beyond is dropped
  function automatic void add_record(kind_t kind, int num, int off, int len, bit endm);
    if (step_records.size() < MAX_PER_BYTE)
      step_records.push_back(make_record(kind, num, off, len, endm));
  endfunction

  function automatic void add_include();
    if (quote1_seen && quote2_seen)
      add_record(KIND_INCLUDE, 0, quote1_pos + 1, quote2_pos - quote1_pos - 1, 1'b0);
  endfunction

  // Walk the window front; without the end known, text decisions need eight bytes
  function automatic void flush_window(bit at_end);
    int    pos;
    int    i;
    byte_t b0;
    byte_t b1;
    bit    hit;
    while (look_q.size() > 0) begin
      pos = sec_count - look_q.size();
      b0  = look(0);
      b1  = look(1);
      if (mode == MODE_INCLUDE_LINE) begin
        drop(1);
        if (b0 == CH_QUOTE) begin
          if (!quote1_seen) begin
            quote1_seen = 1'b1;
            quote1_pos  = pos;
          end else begin
            quote2_seen = 1'b1;
            quote2_pos  = pos;
          end
        end else if (line_end(b0)) begin
          add_include();
          mode = MODE_TEXT;
        end
        continue;
      end
      if (mode == MODE_FLAG_NAME) begin
        drop(1);
        if (name_stop(b0)) begin
          add_record(KIND_FLAG, flag_val, flag_name_pos, pos - flag_name_pos, 1'b0);
          mode = MODE_TEXT;
        end
        continue;
      end
      if (look_q.size() < 8 && !at_end) break;
      // comment openers, then closers
      if (look_q.size() >= 2 && !in_line_cmt && !in_block_cmt) begin
        if (b0 == CH_SLASH && b1 == CH_SLASH) in_line_cmt = 1'b1;
        else if (b0 == CH_SLASH && b1 == CH_STAR) in_block_cmt = 1'b1;
      end
      if (in_line_cmt && line_end(b0))
        in_line_cmt = 1'b0;
      else if (in_block_cmt && look_q.size() >= 2 && b0 == CH_STAR && b1 == CH_SLASH)
        in_block_cmt = 1'b0;
      // #include keyword
      if (!in_line_cmt && !in_block_cmt && look_q.size() >= 8) begin
        hit = 1'b1;
        for (i = 0; i < 8; i++)
          if (look(i) != INCLUDE_WORD[63 - 8 * i -: 8]) hit = 1'b0;
        if (hit) begin
          drop(8);
          mode        = MODE_INCLUDE_LINE;
          quote1_seen = 1'b0;
          quote2_seen = 1'b0;
          quote1_pos  = 0;
          quote2_pos  = 0;
          continue;
        end
      end
      // _Fdd_ flag
      if (!in_line_cmt && !in_block_cmt && look_q.size() >= 5 && b0 == CH_UNDER &&
          b1 == CH_F && look(4) == CH_UNDER && digit(look(2)) && digit(look(3))) begin
        flag_val      = (int'(look(2)) - int'(CH_ZERO)) * 10 + (int'(look(3)) - int'(CH_ZERO));
        flag_name_pos = pos + 5;
        drop(5);
        mode = MODE_FLAG_NAME;
        continue;
      end
      drop(1);
    end
    if (at_end) begin
      if (mode == MODE_INCLUDE_LINE)
        add_include();
      else if (mode == MODE_FLAG_NAME)
        add_record(KIND_FLAG, flag_val, flag_name_pos, sec_count - flag_name_pos, 1'b0);
      add_record(KIND_END, 0, 0, 0, 1'b1);
    end
  endfunction

  // One accepted byte: records it causes land in step_records
  function automatic void scan_section_byte(byte_t c, bit fin);
    step_records.delete();
    if (sec_count < MAX_SECTION_BYTES && look_q.size() < 8) begin
      look_q.push_back(c);
      sec_count++;
    end
    flush_window(fin);
    if (fin) begin
      look_q.delete();
      sec_count     = 0;
      in_line_cmt   = 1'b0;
      in_block_cmt  = 1'b0;
      mode          = MODE_TEXT;
      quote1_seen   = 1'b0;
      quote2_seen   = 1'b0;
      quote1_pos    = 0;
      quote2_pos    = 0;
      flag_val      = 0;
      flag_name_pos = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    $display("[%0t] mismatch on record %0d: %s got %0d want %0d",
             $time, records_out, what, got, want);
  endtask

  // Request monitor: predict on input, compare on output
  always @(posedge clk) begin : monitor
    record_t want;
    if (!rst) begin
      if (text_in.valid && text_in.ready) begin
        scan_section_byte(text_in.text_byte, text_in.final_byte);
        bytes_in++;
        if (!typed_section)
          foreach (step_records[k]) expected_records.push_back(step_records[k]);
        if (text_in.final_byte) begin
          sections_in++;
          typed_section = 1'b0;
        end
      end
      if (record_out.valid && record_out.ready) begin
        records_out++;
        if (expected_records.size() == 0) begin
          report_mismatch("unexpected record, kind", record_out.record_kind, -1);
        end else begin
          want = expected_records.pop_front();
          if (record_out.record_kind != want.kind)
            report_mismatch("record_kind", record_out.record_kind, want.kind);
          if (record_out.flag_number != want.num)
            report_mismatch("flag_number", record_out.flag_number, want.num);
          if (record_out.name_offset != want.off)
            report_mismatch("name_offset", record_out.name_offset, want.off);
          if (record_out.name_length != want.len)
            report_mismatch("name_length", record_out.name_length, want.len);
          if (record_out.end_mark != want.end_mark)
            report_mismatch("end_mark", record_out.end_mark, want.end_mark);
        end
      end
    end
  end

  // Record sink with random back-pressure
  initial begin
    record_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      record_out.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  task automatic send_byte(byte_t b, bit fin);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      text_in.valid <= 1'b0;
      @(posedge clk);
    end
    text_in.valid      <= 1'b1;
    text_in.text_byte  <= b;
    text_in.final_byte <= fin;
    do @(posedge clk); while (!text_in.ready);
  endtask

  task automatic send_section();
    int i;
    for (i = 0; i < section_q.size(); i++)
      send_byte(section_q[i], i == section_q.size() - 1);
  endtask

  // Pause the sender until every outstanding record has come back
  task automatic hold_until_drained();
    text_in.valid <= 1'b0;
    do @(posedge clk); while (expected_records.size() != 0);
  endtask

  function automatic void push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) section_q.push_back(s[i]);
  endfunction

  function automatic void push_name(int n);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0:       section_q.push_back(byte_t'(8'h61 + $urandom_range(0, 25)));
        1:       section_q.push_back(byte_t'(8'h41 + $urandom_range(0, 25)));
        default: section_q.push_back(byte_t'(CH_ZERO + $urandom_range(0, 9)));
      endcase
    end
  endfunction

  function automatic void push_white();
    case ($urandom_range(0, 3))
      0:       section_q.push_back(CH_SPACE);
      1:       section_q.push_back(CH_TAB);
      2:       section_q.push_back(CH_LF);
      default: section_q.push_back(CH_CR);
    endcase
  endfunction

  function automatic void push_body();
    case ($urandom_range(0, 2))
      0:       push_name($urandom_range(1, 6));
      1:       push_text("_F12_x ");
      default: push_text("#include \"c\" ");
    endcase
  endfunction

  // Random section built mostly from well-formed pieces, some noise and broken ones
  function automatic void compose_section();
    int n_quotes;
    section_q.delete();
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 11))
        0, 1, 2: begin // include line
          push_text("#include");
          if ($urandom_range(0, 1) != 0) section_q.push_back(CH_SPACE);
          n_quotes = $urandom_range(0, 5);
          if (n_quotes > 3) n_quotes = 2;
          repeat (n_quotes) begin
            section_q.push_back(CH_QUOTE);
            push_name($urandom_range(0, 4));
          end
          if ($urandom_range(0, 3) == 0) push_text("/*");
          if ($urandom_range(0, 5) != 0)
            section_q.push_back(($urandom_range(0, 1) != 0) ? CH_LF : CH_CR);
        end
        3, 4, 5: begin // flag with a name
          push_text("_F");
          section_q.push_back(byte_t'(CH_ZERO + $urandom_range(0, 9)));
          section_q.push_back(byte_t'(CH_ZERO + $urandom_range(0, 9)));
          section_q.push_back(CH_UNDER);
          push_name($urandom_range(0, 5));
          if ($urandom_range(0, 5) != 0) push_white();
        end
        6: begin // line comment hiding matches
          push_text("//");
          push_body();
          section_q.push_back(($urandom_range(0, 1) != 0) ? CH_LF : CH_CR);
        end
        7: begin // block comment, including the early-closing form
          case ($urandom_range(0, 2))
            0: push_text("/*/");
            1: begin
              push_text("/*");
              push_body();
              push_text("*/");
            end
            default: begin
              push_text("/*");
              push_body();
              push_text("**/");
            end
          endcase
        end
        8: begin // raw noise over the full byte range
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 7))
              0:       section_q.push_back(8'h00);
              1:       section_q.push_back(8'hFF);
              default: section_q.push_back(byte_t'($urandom_range(0, 255)));
            endcase
          end
        end
        9: begin // near misses
          case ($urandom_range(0, 6))
            0:       push_text("#includ");
            1:       push_text("#Include\"a\"\n");
            2:       push_text("_F1x_");
            3:       push_text("_F12");
            4:       push_text("_G12_");
            5:       push_text("_F123_");
            default: push_text("*/ ");
          endcase
        end
        default: begin // plain words
          push_name($urandom_range(1, 6));
          push_white();
        end
      endcase
    end
  endfunction

  function automatic void add_row(string text, int n, record_t r0, record_t r1);
    dir_text.push_back(text);
    dir_count.push_back(n);
    if (n > 0) dir_records.push_back(r0);
    if (n > 1) dir_records.push_back(r1);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  initial begin
    int r;
    int k;
    int t;
    int t_idx;
    int phase;
    int i;
    rst                <= 1'b1;
    text_in.valid      <= 1'b0;
    text_in.text_byte  <= 8'h00;
    text_in.final_byte <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed sections: top byte, empty flag names, flag and opener cut by the end,
    // include with quotes, early-closing block comment
    add_row("\377", 1, END_REC, END_REC);
    add_row("_F99_ ", 2, make_record(KIND_FLAG, 99, 5, 0, 1'b0), END_REC);
    add_row("_F00_", 2, make_record(KIND_FLAG, 0, 5, 0, 1'b0), END_REC);
    add_row("_F12", 1, END_REC, END_REC);
    add_row("/", 1, END_REC, END_REC);
    add_row("#include\"a\"\n", 2, make_record(KIND_INCLUDE, 0, 9, 1, 1'b0), END_REC);
    add_row("/*/_F12_x", -1, END_REC, END_REC);

    t_idx = 0;
    for (r = 0; r < dir_text.size(); r++) begin
      if (dir_count[r] >= 0) begin
        hold_until_drained();
        for (k = 0; k < dir_count[r]; k++) begin
          expected_records.push_back(dir_records[t_idx]);
          t_idx++;
        end
        typed_section = 1'b1;
      end
      section_q.delete();
      push_text(dir_text[r]);
      send_section();
    end

    // Random sections under three idling profiles
    for (phase = 0; phase < 3; phase++) begin
      hold_until_drained();
      in_idle_pct  = (phase == 0) ? 19 : (phase == 1) ? 57 : 0;
      out_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 19 : 0;
      t = 0;
      while (t < 100) begin
        compose_section();
        send_section();
        t += section_q.size();
      end
    end

    // Drain and finish
    text_in.valid <= 1'b0;
    @(posedge clk);
    for (i = 0; i < 20000 && expected_records.size() != 0; i++) @(posedge clk);
    repeat (30) @(posedge clk);
    if (expected_records.size() != 0)
      report_mismatch("records never produced, count", 0, expected_records.size());

    $display("scanned %0d bytes in %0d sections: directed cases, then random text",
             bytes_in, sections_in);
    $display("under three back-pressure mixes; compared %0d records, %0d mismatches",
             records_out, error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
